// ----- rtl/core/lti_pkg.sv -----
// shared types and constants for the line / triangle intersection pipeline
// no dependencies
`default_nettype none

package lti_pkg;

  localparam int COORD_BITS_DEF = 21;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_ADDR_BITS  = 5;

  // register index, taken from paddr bits above the 8-byte word offset
  localparam logic [1:0] REG_VERTEX_A = 2'd0;
  localparam logic [1:0] REG_VERTEX_B = 2'd1;
  localparam logic [1:0] REG_VERTEX_C = 2'd2;

  typedef enum logic [1:0] {
    ST_INSIDE   = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_PARALLEL = 2'd2,
    ST_BEHIND   = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/line_triangle_intersection.sv -----
// line / triangle intersection: plane hit, rounding divide, same-side tests
// depends on lti_pkg
//
// Usage: write the three vertices over the APB-style port (vertex_a at 0x00,
// vertex_b at 0x08, vertex_c at 0x10; x in the lowest field, then y, z).
// Each input beat carries a line start and a second point on the line; each
// beat gives exactly one result beat: hit flag, status and the rounded,
// saturated intersection point (zero when parallel or behind the start).
// One beat is accepted per cycle while in_stall is low. The hit point comes
// from a restoring divider, one quotient bit per stage per coordinate
// (COORD_BITS + 2 stages), with multiply, sum and sign stages around it.
// Stages that hold no beat take new data even when the result is stalled,
// so in_stall only rises once every stage is full and out_stall is high.
// Reset (rst_n low at a clock edge) empties the pipeline and clears the
// vertex registers to zero. Vertices may be written only while the pipeline
// is empty.
`default_nettype none

module line_triangle_intersection
  import lti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  signed [COORD_BITS-1:0]     in_start_x,
  input  wire  signed [COORD_BITS-1:0]     in_start_y,
  input  wire  signed [COORD_BITS-1:0]     in_start_z,
  input  wire  signed [COORD_BITS-1:0]     in_toward_x,
  input  wire  signed [COORD_BITS-1:0]     in_toward_y,
  input  wire  signed [COORD_BITS-1:0]     in_toward_z,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_hit,
  output logic [1:0]                       out_status,
  output logic signed [COORD_BITS-1:0]     out_cross_x,
  output logic signed [COORD_BITS-1:0]     out_cross_y,
  output logic signed [COORD_BITS-1:0]     out_cross_z,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [CFG_ADDR_BITS-1:0]         paddr,
  input  wire  [CFG_DATA_BITS-1:0]         pwdata,
  output logic [CFG_DATA_BITS-1:0]         prdata,
  output logic                             pready
);

  localparam int W   = COORD_BITS;
  localparam int VW  = 3 * W;
  localparam int D   = W + 1;            // coordinate difference
  localparam int NW  = 2 * D + 1;         // cross product component
  localparam int PW  = D + NW;            // dot product term
  localparam int DW  = PW + 2;            // dot product sum
  localparam int QB  = W + 2;             // quotient bits before saturation
  localparam int RW  = DW + D;            // |num * l| and divider remainder
  localparam int NLO = DW / 2;
  localparam int NHI = DW - NLO;
  localparam int CLO = NW / 2;
  localparam int CHI = NW - CLO;
  localparam int XLW = CLO + 1 + NW;
  localparam int XHW = CHI + NW;
  localparam int SW  = 2 * NW;
  localparam int CW  = W + 4;

  localparam int S_IN  = 0;
  localparam int S_PRD = 1;
  localparam int S_SUM = 2;
  localparam int S_ABS = 3;
  localparam int S_PP  = 4;
  localparam int S_PM  = 5;
  localparam int S_OVF = 6;
  localparam int S_DIV = 7;
  localparam int S_RND = S_DIV + QB;
  localparam int S_PT  = S_RND + 1;
  localparam int S_X1  = S_PT + 1;
  localparam int S_X2  = S_X1 + 1;
  localparam int S_X3  = S_X2 + 1;
  localparam int S_OUT = S_X3 + 1;
  localparam int NST   = S_OUT + 1;

  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [QB:0] SAT_LIM = (QB+1)'(1) << (W + 1);

  // same-side tests: edge u->v, reference vertex r
  localparam int TU [3] = '{1, 0, 0};
  localparam int TV [3] = '{2, 2, 1};
  localparam int TR [3] = '{0, 1, 2};

  // ---------------------------------------------------------------- config
  logic [VW-1:0] cfg_vtx_r [3];
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_vtx_r[0] <= '0;
      cfg_vtx_r[1] <= '0;
      cfg_vtx_r[2] <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_VERTEX_A: cfg_vtx_r[0] <= pwdata[VW-1:0];
        REG_VERTEX_B: cfg_vtx_r[1] <= pwdata[VW-1:0];
        REG_VERTEX_C: cfg_vtx_r[2] <= pwdata[VW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_VERTEX_A: prdata = CFG_DATA_BITS'(cfg_vtx_r[0]);
      REG_VERTEX_B: prdata = CFG_DATA_BITS'(cfg_vtx_r[1]);
      REG_VERTEX_C: prdata = CFG_DATA_BITS'(cfg_vtx_r[2]);
      default:      prdata = '0;
    endcase
  end

  logic signed [W-1:0] vtx [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        vtx[k][i] = cfg_vtx_r[k][i*W +: W];
      end
    end
  end

  // triangle terms only change with the vertices, so they run free of the beats
  logic signed [D-1:0]  e1      [3];
  logic signed [D-1:0]  e2      [3];
  logic signed [D-1:0]  ed_nxt  [3][3];
  logic signed [D-1:0]  dr_v    [3][3];
  logic signed [NW-1:0] n_r     [3];
  logic signed [D-1:0]  ed_r    [3][3];
  logic signed [NW-1:0] c2_r    [3][3];
  logic signed [NW-1:0] n_nxt   [3];
  logic signed [NW-1:0] c2_nxt  [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = D'(vtx[2][i]) - D'(vtx[1][i]);
      e2[i] = D'(vtx[1][i]) - D'(vtx[0][i]);
    end
    for (int i = 0; i < 3; i++) begin
      n_nxt[i] = NW'(NW'(e1[(i+1)%3]) * NW'(e2[(i+2)%3]))
               - NW'(NW'(e1[(i+2)%3]) * NW'(e2[(i+1)%3]));
    end
    for (int t = 0; t < 3; t++) begin
      for (int i = 0; i < 3; i++) begin
        ed_nxt[t][i] = D'(vtx[TV[t]][i]) - D'(vtx[TU[t]][i]);
        dr_v[t][i]   = D'(vtx[TR[t]][i]) - D'(vtx[TU[t]][i]);
      end
      for (int i = 0; i < 3; i++) begin
        c2_nxt[t][i] = NW'(NW'(ed_nxt[t][(i+1)%3]) * NW'(dr_v[t][(i+2)%3]))
                     - NW'(NW'(ed_nxt[t][(i+2)%3]) * NW'(dr_v[t][(i+1)%3]));
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r  <= n_nxt;
    ed_r <= ed_nxt;
    c2_r <= c2_nxt;
  end

  // ------------------------------------------------------ valid / enables
  logic [NST-1:0] vld_r;
  logic [NST:0]   en;
  logic [NST-1:0] vld_nxt;

  assign en[NST]  = !out_stall;
  assign vld_nxt  = {vld_r[NST-2:0], in_valid};
  assign in_stall = !en[0];
  assign out_valid = vld_r[NST-1];

  for (genvar k = 0; k < NST; k++) begin : g_vld
    // a stage moves when it is empty or the next one moves
    assign en[k] = !vld_r[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en[k]) begin
        vld_r[k] <= vld_nxt[k];
      end
    end
  end

  // --------------------------------------------------- stage: differences
  logic signed [W-1:0] in_s  [3];
  logic signed [W-1:0] in_e  [3];
  logic signed [W-1:0] s0_r  [3];
  logic signed [D-1:0] l0_r  [3];
  logic signed [D-1:0] as0_r [3];

  assign in_s = '{in_start_x, in_start_y, in_start_z};
  assign in_e = '{in_toward_x, in_toward_y, in_toward_z};

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      for (int i = 0; i < 3; i++) begin
        s0_r[i]  <= in_s[i];
        l0_r[i]  <= D'(in_e[i]) - D'(in_s[i]);
        as0_r[i] <= D'(vtx[0][i]) - D'(in_s[i]);
      end
    end
  end

  // ------------------------------------------------ stage: dot products
  logic signed [PW-1:0] pd1_r [3];
  logic signed [PW-1:0] pn1_r [3];
  logic signed [W-1:0]  s1_r  [3];
  logic signed [D-1:0]  l1_r  [3];

  always_ff @(posedge clk) begin
    if (en[S_PRD]) begin
      for (int i = 0; i < 3; i++) begin
        pd1_r[i] <= PW'(l0_r[i]) * PW'(n_r[i]);
        pn1_r[i] <= PW'(as0_r[i]) * PW'(n_r[i]);
        s1_r[i]  <= s0_r[i];
        l1_r[i]  <= l0_r[i];
      end
    end
  end

  logic signed [DW-1:0] den2_r;
  logic signed [DW-1:0] num2_r;
  logic signed [W-1:0]  s2_r [3];
  logic signed [D-1:0]  l2_r [3];

  always_ff @(posedge clk) begin
    if (en[S_SUM]) begin
      den2_r <= DW'(pd1_r[0]) + DW'(pd1_r[1]) + DW'(pd1_r[2]);
      num2_r <= DW'(pn1_r[0]) + DW'(pn1_r[1]) + DW'(pn1_r[2]);
      s2_r   <= s1_r;
      l2_r   <= l1_r;
    end
  end

  // ------------------------------------------- stage: classify, magnitudes
  status_t             cls3_r;
  logic [DW-1:0]       dm3_r;
  logic [DW-1:0]       an3_r;
  logic [D-1:0]        al3_r  [3];
  logic                neg3_r [3];
  logic signed [W-1:0] s3_r   [3];
  status_t             cls_nxt;

  always_comb begin
    if (den2_r == '0) begin
      cls_nxt = ST_PARALLEL;
    end else if (num2_r != '0 && (num2_r[DW-1] != den2_r[DW-1])) begin
      cls_nxt = ST_BEHIND;
    end else begin
      cls_nxt = ST_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_ABS]) begin
      cls3_r <= cls_nxt;
      dm3_r  <= den2_r[DW-1] ? DW'(-den2_r) : DW'(den2_r);
      an3_r  <= num2_r[DW-1] ? DW'(-num2_r) : DW'(num2_r);
      for (int i = 0; i < 3; i++) begin
        al3_r[i]  <= l2_r[i][D-1] ? D'(-l2_r[i]) : D'(l2_r[i]);
        neg3_r[i] <= num2_r[DW-1] ^ l2_r[i][D-1] ^ den2_r[DW-1];
        s3_r[i]   <= s2_r[i];
      end
    end
  end

  // ------------------------------------ stage: |num| * |l| partial products
  logic [NLO+D-1:0]    plo4_r [3];
  logic [NHI+D-1:0]    phi4_r [3];
  status_t             cls4_r;
  logic [DW-1:0]       dm4_r;
  logic                neg4_r [3];
  logic signed [W-1:0] s4_r   [3];

  always_ff @(posedge clk) begin
    if (en[S_PP]) begin
      for (int i = 0; i < 3; i++) begin
        plo4_r[i] <= (NLO+D)'(an3_r[NLO-1:0]) * (NLO+D)'(al3_r[i]);
        phi4_r[i] <= (NHI+D)'(an3_r[DW-1:NLO]) * (NHI+D)'(al3_r[i]);
      end
      cls4_r <= cls3_r;
      dm4_r  <= dm3_r;
      neg4_r <= neg3_r;
      s4_r   <= s3_r;
    end
  end

  logic [RW-1:0]       pm5_r [3];
  status_t             cls5_r;
  logic [DW-1:0]       dm5_r;
  logic                neg5_r [3];
  logic signed [W-1:0] s5_r   [3];

  always_ff @(posedge clk) begin
    if (en[S_PM]) begin
      for (int i = 0; i < 3; i++) begin
        pm5_r[i] <= RW'(plo4_r[i]) + (RW'(phi4_r[i]) << NLO);
      end
      cls5_r <= cls4_r;
      dm5_r  <= dm4_r;
      neg5_r <= neg4_r;
      s5_r   <= s4_r;
    end
  end

  // ------------------------------------------------------------ divider
  // entry 0 is loaded by the overflow check, entry k+1 by quotient step k
  logic [RW-1:0]       drm_r [QB+1][3];
  logic [QB-1:0]       dq_r  [QB+1][3];
  logic                dov_r [QB+1][3];
  logic                dng_r [QB+1][3];
  logic signed [W-1:0] ds_r  [QB+1][3];
  status_t             dcl_r [QB+1];
  logic [DW-1:0]       ddm_r [QB+1];

  always_ff @(posedge clk) begin
    if (en[S_OVF]) begin
      for (int i = 0; i < 3; i++) begin
        // quotient of 2^QB or more always saturates
        dov_r[0][i] <= (RW+1)'(pm5_r[i]) >= ((RW+1)'(dm5_r) << QB);
        drm_r[0][i] <= pm5_r[i];
        dq_r[0][i]  <= '0;
      end
      dng_r[0] <= neg5_r;
      ds_r[0]  <= s5_r;
      dcl_r[0] <= cls5_r;
      ddm_r[0] <= dm5_r;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int J = QB - 1 - k;
    logic [RW-1:0] sub;
    logic          ge   [3];

    assign sub = RW'(ddm_r[k]) << J;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = drm_r[k][i] >= sub;
      end
    end

    always_ff @(posedge clk) begin
      if (en[S_DIV+k]) begin
        for (int i = 0; i < 3; i++) begin
          drm_r[k+1][i] <= ge[i] ? drm_r[k][i] - sub : drm_r[k][i];
          dq_r[k+1][i]  <= dq_r[k][i] | (ge[i] ? (QB'(1) << J) : '0);
        end
        dov_r[k+1] <= dov_r[k];
        dng_r[k+1] <= dng_r[k];
        ds_r[k+1]  <= ds_r[k];
        dcl_r[k+1] <= dcl_r[k];
        ddm_r[k+1] <= ddm_r[k];
      end
    end
  end

  // -------------------------------------------- stage: round half away
  logic [QB:0]         qr_r   [3];
  logic                ov6_r  [3];
  logic                neg6_r [3];
  logic signed [W-1:0] s6_r   [3];
  status_t             cls6_r;

  always_ff @(posedge clk) begin
    if (en[S_RND]) begin
      for (int i = 0; i < 3; i++) begin
        qr_r[i] <= (QB+1)'(dq_r[QB][i])
                 + (QB+1)'({drm_r[QB][i], 1'b0} >= (RW+1)'(ddm_r[QB]));
      end
      ov6_r  <= dov_r[QB];
      neg6_r <= dng_r[QB];
      s6_r   <= ds_r[QB];
      cls6_r <= dcl_r[QB];
    end
  end

  // --------------------------------------------- stage: point and clamp
  logic signed [W-1:0]  p7_r [3];
  status_t              cls7_r;
  logic signed [CW-1:0] mag  [3];
  logic signed [CW-1:0] csum [3];
  logic signed [W-1:0]  pt_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]  = CW'($signed({1'b0, qr_r[i]}));
      csum[i] = CW'(s6_r[i]) + (neg6_r[i] ? -mag[i] : mag[i]);
      if (cls6_r != ST_INSIDE) begin
        pt_nxt[i] = '0;
      end else if (ov6_r[i] || qr_r[i] > SAT_LIM) begin
        pt_nxt[i] = neg6_r[i] ? CMIN : CMAX;
      end else if (csum[i] > CW'(CMAX)) begin
        pt_nxt[i] = CMAX;
      end else if (csum[i] < CW'(CMIN)) begin
        pt_nxt[i] = CMIN;
      end else begin
        pt_nxt[i] = csum[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_PT]) begin
      p7_r   <= pt_nxt;
      cls7_r <= cls6_r;
    end
  end

  // --------------------------------------------- same-side cross products
  logic signed [NW-1:0] c1_r [3][3];
  logic signed [W-1:0]  p8_r [3];
  status_t              cls8_r;
  logic signed [D-1:0]  dp   [3][3];

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      for (int i = 0; i < 3; i++) begin
        dp[t][i] = D'(p7_r[i]) - D'(vtx[TU[t]][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_X1]) begin
      for (int t = 0; t < 3; t++) begin
        for (int i = 0; i < 3; i++) begin
          c1_r[t][i] <= NW'(NW'(ed_r[t][(i+1)%3]) * NW'(dp[t][(i+2)%3]))
                      - NW'(NW'(ed_r[t][(i+2)%3]) * NW'(dp[t][(i+1)%3]));
        end
      end
      p8_r   <= p7_r;
      cls8_r <= cls7_r;
    end
  end

  // dot(c1, c2) split on c1 into a low unsigned and a high signed half
  logic signed [XLW-1:0] xl_r [3][3];
  logic signed [XHW-1:0] xh_r [3][3];
  logic signed [W-1:0]   p9_r [3];
  status_t               cls9_r;

  always_ff @(posedge clk) begin
    if (en[S_X2]) begin
      for (int t = 0; t < 3; t++) begin
        for (int i = 0; i < 3; i++) begin
          xl_r[t][i] <= XLW'($signed({1'b0, c1_r[t][i][CLO-1:0]})) * XLW'(c2_r[t][i]);
          xh_r[t][i] <= XHW'($signed(c1_r[t][i][NW-1:CLO])) * XHW'(c2_r[t][i]);
        end
      end
      p9_r   <= p8_r;
      cls9_r <= cls8_r;
    end
  end

  logic signed [SW-1:0] xs_r  [3][3];
  logic signed [W-1:0]  p10_r [3];
  status_t              cls10_r;

  always_ff @(posedge clk) begin
    if (en[S_X3]) begin
      for (int t = 0; t < 3; t++) begin
        for (int i = 0; i < 3; i++) begin
          xs_r[t][i] <= SW'(xl_r[t][i]) + (SW'(xh_r[t][i]) <<< CLO);
        end
      end
      p10_r   <= p9_r;
      cls10_r <= cls9_r;
    end
  end

  // ------------------------------------------------------- result stage
  logic signed [SW+1:0] dot  [3];
  logic                 side_ok;
  status_t              st_nxt;

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      dot[t] = (SW+2)'(xs_r[t][0]) + (SW+2)'(xs_r[t][1]) + (SW+2)'(xs_r[t][2]);
    end
    side_ok = !dot[0][SW+1] && !dot[1][SW+1] && !dot[2][SW+1];
    if (cls10_r != ST_INSIDE) begin
      st_nxt = cls10_r;
    end else begin
      st_nxt = side_ok ? ST_INSIDE : ST_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      out_status  <= st_nxt;
      out_hit     <= (st_nxt == ST_INSIDE);
      out_cross_x <= p10_r[0];
      out_cross_y <= p10_r[1];
      out_cross_z <= p10_r[2];
    end
  end

  // ---------------------------------------------------------- assertions
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while pipeline can move");

  a_hit_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (out_status == ST_INSIDE)))
    else $error("hit flag disagrees with status");

  a_no_point_when_missed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_PARALLEL || out_status == ST_BEHIND))
      |-> (out_cross_x == '0 && out_cross_y == '0 && out_cross_z == '0))
    else $error("point not zero for parallel or behind");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S_RND-1] && dcl_r[QB] == ST_INSIDE && !dov_r[QB][0])
      |-> (drm_r[QB][0] < RW'(ddm_r[QB])))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
